@@ src/jsve_pkg.sv @@
package jsve_pkg;

    localparam int CHAR_W = 8;
    localparam int KIND_W = 2;

    localparam logic [CHAR_W-1:0] CH_QUOTE = 8'h22;
    localparam logic [CHAR_W-1:0] CH_BSL   = 8'h5C;
    localparam logic [CHAR_W-1:0] CH_COLON = 8'h3A;
    localparam logic [CHAR_W-1:0] CH_N     = 8'h6E;
    localparam logic [CHAR_W-1:0] CH_R     = 8'h72;
    localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_SP    = 8'h20;
    localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
    localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;

    localparam logic [KIND_W-1:0] KIND_BYTE = 2'd0;
    localparam logic [KIND_W-1:0] KIND_END  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_ABAN = 2'd2;
    localparam logic [KIND_W-1:0] KIND_BAD  = 2'd3;

    function automatic logic is_ws(input logic [CHAR_W-1:0] c);
        return (c == CH_SP) || ((c >= CH_TAB) && (c <= CH_CR));
    endfunction

endpackage

@@ src/json_string_value_extractor_unit.sv @@
// Streaming parser for the text of a flat JSON object, one byte per item. Each
// string value that follows a quoted key and a colon comes out byte by byte,
// unescaped (backslash-n gives newline, backslash-r carriage return, a
// backslash before any other byte gives that byte), followed by an end-of-value
// item; key text is skipped. A zero byte or i_end_of_text ends the text, and a
// value still open then is reported by an abandoned item. Bytes that yield no
// result produce no output item. The block takes one byte per cycle unless a
// byte with a result meets an unread output register; an accepted byte passes
// from the input register to the output register. The input and output
// registers separate the two handshakes, so a new byte can be taken while a
// result waits to be read.
module json_string_value_extractor_unit (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic [jsve_pkg::CHAR_W-1:0] i_char_code,
    input  logic                        i_end_of_text,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic [jsve_pkg::CHAR_W-1:0] o_out_byte,
    output logic [jsve_pkg::KIND_W-1:0] o_out_kind
);

    localparam logic [2:0] PH_SCAN      = 3'd0;
    localparam logic [2:0] PH_KEY       = 3'd1;
    localparam logic [2:0] PH_KEY_ESC   = 3'd2;
    localparam logic [2:0] PH_AFTER_KEY = 3'd3;
    localparam logic [2:0] PH_AFTER_COL = 3'd4;
    localparam logic [2:0] PH_VALUE     = 3'd5;
    localparam logic [2:0] PH_VALUE_ESC = 3'd6;
    localparam logic [2:0] PH_UNUSED    = 3'd7;

    logic [2:0]                  r_phase;
    logic [2:0]                  n_phase;
    logic                        r_in_valid;
    logic [jsve_pkg::CHAR_W-1:0] r_in_char;
    logic                        r_in_eot;
    logic                        r_out_valid;
    logic [jsve_pkg::CHAR_W-1:0] r_out_byte;
    logic [jsve_pkg::KIND_W-1:0] r_out_kind;

    logic                        w_emit;
    logic [jsve_pkg::CHAR_W-1:0] w_byte;
    logic [jsve_pkg::KIND_W-1:0] w_kind;
    logic                        w_advance;
    logic                        w_in_take;

    always_comb begin
        n_phase = r_phase;
        w_emit  = 1'b0;
        w_byte  = jsve_pkg::CH_NUL;
        w_kind  = jsve_pkg::KIND_BYTE;
        if (r_in_eot || (r_in_char == jsve_pkg::CH_NUL)) begin
            n_phase = PH_SCAN;
            if ((r_phase == PH_VALUE) || (r_phase == PH_VALUE_ESC)) begin
                w_emit = 1'b1;
                w_kind = jsve_pkg::KIND_ABAN;
            end
        end else begin
            unique case (r_phase)
                PH_KEY: begin
                    if (r_in_char == jsve_pkg::CH_BSL) begin
                        n_phase = PH_KEY_ESC;
                    end else if (r_in_char == jsve_pkg::CH_QUOTE) begin
                        n_phase = PH_AFTER_KEY;
                    end
                end
                PH_KEY_ESC: begin
                    n_phase = PH_KEY;
                end
                PH_AFTER_KEY: begin
                    if (!jsve_pkg::is_ws(r_in_char)) begin
                        if (r_in_char == jsve_pkg::CH_COLON) begin
                            n_phase = PH_AFTER_COL;
                        end else if (r_in_char == jsve_pkg::CH_QUOTE) begin
                            n_phase = PH_KEY;
                        end else begin
                            n_phase = PH_SCAN;
                        end
                    end
                end
                PH_AFTER_COL: begin
                    if (!jsve_pkg::is_ws(r_in_char)) begin
                        n_phase = (r_in_char == jsve_pkg::CH_QUOTE) ? PH_VALUE : PH_SCAN;
                    end
                end
                PH_VALUE: begin
                    if (r_in_char == jsve_pkg::CH_BSL) begin
                        n_phase = PH_VALUE_ESC;
                    end else if (r_in_char == jsve_pkg::CH_QUOTE) begin
                        n_phase = PH_SCAN;
                        w_emit  = 1'b1;
                        w_kind  = jsve_pkg::KIND_END;
                    end else begin
                        w_emit = 1'b1;
                        w_byte = r_in_char;
                    end
                end
                PH_VALUE_ESC: begin
                    n_phase = PH_VALUE;
                    w_emit  = 1'b1;
                    if (r_in_char == jsve_pkg::CH_N) begin
                        w_byte = jsve_pkg::CH_LF;
                    end else if (r_in_char == jsve_pkg::CH_R) begin
                        w_byte = jsve_pkg::CH_CR;
                    end else begin
                        w_byte = r_in_char;
                    end
                end
                default: begin
                    n_phase = (r_in_char == jsve_pkg::CH_QUOTE) ? PH_KEY : PH_SCAN;
                end
            endcase
        end
    end

    // stage item moves on when its result, if any, finds room
    assign w_advance   = r_in_valid && (!w_emit || !r_out_valid || i_out_ready);
    assign o_in_ready  = !r_in_valid || w_advance;
    assign w_in_take   = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_byte  = r_out_byte;
    assign o_out_kind  = r_out_kind;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_SCAN;
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_advance) begin
                r_phase <= n_phase;
            end
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (w_advance && w_emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_in_char <= i_char_code;
            r_in_eot  <= i_end_of_text;
        end
        if (w_advance && w_emit) begin
            r_out_byte <= w_byte;
            r_out_kind <= w_kind;
        end
    end

`ifndef SYNTHESIS
    a_kind_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_kind != jsve_pkg::KIND_BAD))
        else $error("illegal result kind");

    a_marker_byte_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_kind != jsve_pkg::KIND_BYTE)) |-> (o_out_byte == jsve_pkg::CH_NUL))
        else $error("end or abandon item with nonzero byte");

    a_phase_reachable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase != PH_UNUSED)
        else $error("unused phase reached");

    a_eot_rescans: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_advance && r_in_eot) |=> (r_phase == PH_SCAN))
        else $error("end of text did not return to scanning");
`endif

endmodule

@@ tb/json_string_value_extractor_unit_tb.sv @@
`timescale 1ns / 1ps

module json_string_value_extractor_unit_tb;
    import jsve_pkg::*;

    localparam int CYCLE_LIMIT = 600000;
    localparam int RANDOM_ITEMS = 700;
    localparam int DIR_N = 34;

    localparam logic [CHAR_W-1:0] CH_VT     = 8'h0B;
    localparam logic [CHAR_W-1:0] CH_FF     = 8'h0C;
    localparam logic [CHAR_W-1:0] CH_LBRACE = 8'h7B;
    localparam logic [CHAR_W-1:0] CH_RBRACE = 8'h7D;
    localparam logic [CHAR_W-1:0] CH_COMMA  = 8'h2C;
    localparam logic [CHAR_W-1:0] BLANKS [6] = '{CH_SP, CH_TAB, CH_LF, CH_VT, CH_FF, CH_CR};

    typedef enum logic [2:0] {
        PH_SCAN, PH_KEY, PH_KEY_ESC, PH_AFTER_KEY, PH_AFTER_COL, PH_VALUE, PH_VALUE_ESC
    } parse_phase_t;

    typedef enum logic [1:0] {ROW_PRED, ROW_NONE, ROW_RES} row_mode_t;

    typedef struct packed {
        logic [CHAR_W-1:0] ch;
        logic              eot;
        row_mode_t         mode;
        logic [CHAR_W-1:0] rb;
        logic [KIND_W-1:0] rk;
    } stim_row_t;

    typedef struct packed {
        logic [CHAR_W-1:0] b;
        logic [KIND_W-1:0] k;
    } value_item_t;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_in_valid = 1'b0;
    logic              o_in_ready;
    logic [CHAR_W-1:0] i_char_code = '0;
    logic              i_end_of_text = 1'b0;
    logic              o_out_valid;
    logic              i_out_ready = 1'b0;
    logic [CHAR_W-1:0] o_out_byte;
    logic [KIND_W-1:0] o_out_kind;

    parse_phase_t  parse_phase = PH_SCAN;
    value_item_t   pending_values [$];
    int            err_cnt = 0;
    int            sent_cnt = 0;
    int            cycle_cnt = 0;
    bit            tx_burst = 1'b0;

    // directed text: key escapes, value escapes, stray bytes, text ends
    stim_row_t dir_rows [DIR_N] = '{
        '{8'hFF,    1'b1, ROW_NONE, 8'h00, KIND_BYTE},
        '{CH_QUOTE, 1'b0, ROW_PRED, 8'h00, KIND_BYTE},
        '{CH_BSL,   1'b0, ROW_PRED, 8'h00, KIND_BYTE},
        '{CH_QUOTE, 1'b0, ROW_PRED, 8'h00, KIND_BYTE},
        '{CH_QUOTE, 1'b0, ROW_PRED, 8'h00, KIND_BYTE},
        '{CH_SP,    1'b0, ROW_PRED, 8'h00, KIND_BYTE},
        '{CH_COLON, 1'b0, ROW_PRED, 8'h00, KIND_BYTE},
        '{CH_TAB,   1'b0, ROW_PRED, 8'h00, KIND_BYTE},
        '{CH_QUOTE, 1'b0, ROW_PRED, 8'h00, KIND_BYTE},
        '{8'hFF,    1'b0, ROW_RES,  8'hFF, KIND_BYTE},
        '{CH_BSL,   1'b0, ROW_PRED, 8'h00, KIND_BYTE},
        '{CH_N,     1'b0, ROW_RES,  CH_LF, KIND_BYTE},
        '{CH_BSL,   1'b0, ROW_PRED, 8'h00, KIND_BYTE},
        '{CH_R,     1'b0, ROW_RES,  CH_CR, KIND_BYTE},
        '{CH_BSL,   1'b0, ROW_PRED, 8'h00, KIND_BYTE},
        '{CH_QUOTE, 1'b0, ROW_RES,  CH_QUOTE, KIND_BYTE},
        '{8'h01,    1'b0, ROW_PRED, 8'h00, KIND_BYTE},
        '{CH_QUOTE, 1'b0, ROW_RES,  8'h00, KIND_END},
        '{CH_QUOTE, 1'b0, ROW_PRED, 8'h00, KIND_BYTE},
        '{CH_QUOTE, 1'b0, ROW_PRED, 8'h00, KIND_BYTE},
        '{8'h78,    1'b0, ROW_PRED, 8'h00, KIND_BYTE},
        '{CH_QUOTE, 1'b0, ROW_PRED, 8'h00, KIND_BYTE},
        '{CH_QUOTE, 1'b0, ROW_PRED, 8'h00, KIND_BYTE},
        '{CH_QUOTE, 1'b0, ROW_PRED, 8'h00, KIND_BYTE},
        '{CH_QUOTE, 1'b0, ROW_PRED, 8'h00, KIND_BYTE},
        '{CH_COLON, 1'b0, ROW_PRED, 8'h00, KIND_BYTE},
        '{8'h7A,    1'b0, ROW_PRED, 8'h00, KIND_BYTE},
        '{CH_QUOTE, 1'b0, ROW_PRED, 8'h00, KIND_BYTE},
        '{CH_QUOTE, 1'b0, ROW_PRED, 8'h00, KIND_BYTE},
        '{CH_COLON, 1'b0, ROW_PRED, 8'h00, KIND_BYTE},
        '{CH_QUOTE, 1'b0, ROW_PRED, 8'h00, KIND_BYTE},
        '{CH_BSL,   1'b0, ROW_PRED, 8'h00, KIND_BYTE},
        '{8'h00,    1'b1, ROW_RES,  8'h00, KIND_ABAN},
        '{CH_NUL,   1'b0, ROW_NONE, 8'h00, KIND_BYTE}
    };

    json_string_value_extractor_unit i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_char_code   (i_char_code),
        .i_end_of_text (i_end_of_text),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_out_byte    (o_out_byte),
        .o_out_kind    (o_out_kind)
    );

    always #5 i_clk = ~i_clk;

    function automatic logic is_blank(input logic [CHAR_W-1:0] c);
        return (c == CH_SP) || (c == CH_TAB) || (c == CH_LF) || (c == CH_VT)
            || (c == CH_FF) || (c == CH_CR);
    endfunction

    // next parser phase and the value item that one byte yields
    function automatic logic extract_value(input logic [CHAR_W-1:0] c, input logic eot,
                                           output value_item_t res);
        parse_phase_t ph;
        logic hit;
        ph = parse_phase;
        hit = 1'b0;
        res.b = 8'h00;
        res.k = KIND_BYTE;
        if (eot || c == CH_NUL) begin
            parse_phase = PH_SCAN;
            if (ph == PH_VALUE || ph == PH_VALUE_ESC) begin
                res.k = KIND_ABAN;
                hit = 1'b1;
            end
        end else begin
            case (ph)
                PH_KEY: begin
                    if (c == CH_BSL)
                        parse_phase = PH_KEY_ESC;
                    else if (c == CH_QUOTE)
                        parse_phase = PH_AFTER_KEY;
                end
                PH_KEY_ESC: parse_phase = PH_KEY;
                PH_AFTER_KEY: begin
                    if (!is_blank(c)) begin
                        if (c == CH_COLON)
                            parse_phase = PH_AFTER_COL;
                        else if (c == CH_QUOTE)
                            parse_phase = PH_KEY;
                        else
                            parse_phase = PH_SCAN;
                    end
                end
                PH_AFTER_COL: begin
                    if (!is_blank(c)) begin
                        if (c == CH_QUOTE)
                            parse_phase = PH_VALUE;
                        else
                            parse_phase = PH_SCAN;
                    end
                end
                PH_VALUE: begin
                    if (c == CH_BSL) begin
                        parse_phase = PH_VALUE_ESC;
                    end else if (c == CH_QUOTE) begin
                        parse_phase = PH_SCAN;
                        res.k = KIND_END;
                        hit = 1'b1;
                    end else begin
                        res.b = c;
                        hit = 1'b1;
                    end
                end
                PH_VALUE_ESC: begin
                    parse_phase = PH_VALUE;
                    res.b = (c == CH_N) ? CH_LF : (c == CH_R) ? CH_CR : c;
                    hit = 1'b1;
                end
                default: begin
                    if (c == CH_QUOTE)
                        parse_phase = PH_KEY;
                    else
                        parse_phase = PH_SCAN;
                end
            endcase
        end
        return hit;
    endfunction

    function automatic int pick_gap(input bit burst);
        int r;
        r = $urandom_range(0, 99);
        if (burst || r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic send_item(input logic [CHAR_W-1:0] ch, input logic eot, input row_mode_t mode,
                             input logic [CHAR_W-1:0] rb, input logic [KIND_W-1:0] rk);
        int gap;
        value_item_t res;
        logic hit;
        if ($urandom_range(0, 59) == 0)
            tx_burst = !tx_burst;
        gap = pick_gap(tx_burst);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_char_code <= ch;
        i_end_of_text <= eot;
        do @(posedge i_clk); while (!o_in_ready);
        hit = extract_value(ch, eot, res);
        if (mode == ROW_PRED && hit)
            pending_values.push_back(res);
        else if (mode == ROW_RES)
            pending_values.push_back('{b: rb, k: rk});
        sent_cnt++;
    endtask

    task automatic send_char(input logic [CHAR_W-1:0] ch);
        send_item(ch, 1'b0, ROW_PRED, 8'h00, KIND_BYTE);
    endtask

    task automatic gen_blank();
        logic [2:0] bi;
        repeat ($urandom_range(0, 2)) begin
            bi = 3'($urandom_range(0, 5));
            send_char(BLANKS[bi]);
        end
    endtask

    // quoted string with random content; cut drops the closing quote and sends a last byte that may end the text
    task automatic gen_string(input bit is_value, input bit cut);
        logic [CHAR_W-1:0] c;
        int r;
        int len;
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 20) : $urandom_range(0, 8);
        send_char(CH_QUOTE);
        repeat (len) begin
            r = $urandom_range(0, 99);
            if (r < 15) begin
                send_char(CH_BSL);
                case ($urandom_range(0, 4))
                    0: c = CH_N;
                    1: c = CH_R;
                    2: c = CH_QUOTE;
                    3: c = CH_BSL;
                    default: c = CHAR_W'($urandom_range(1, 255));
                endcase
            end else begin
                c = is_value ? CHAR_W'($urandom_range(1, 255))
                             : CHAR_W'($urandom_range(8'h20, 8'h7E));
                if (c == CH_QUOTE || c == CH_BSL)
                    c = 8'h6B;
            end
            send_char(c);
        end
        if (cut) begin
            if ($urandom_range(0, 1))
                send_char(CH_BSL);
            send_item($urandom_range(0, 1) ? CHAR_W'($urandom_range(0, 255)) : CH_NUL,
                      1'($urandom_range(0, 1)), ROW_PRED, 8'h00, KIND_BYTE);
        end else begin
            send_char(CH_QUOTE);
        end
    endtask

    task automatic gen_object();
        int pairs;
        int r;
        logic [CHAR_W-1:0] c;
        if ($urandom_range(0, 19) == 0)
            repeat ($urandom_range(1, 6))
                send_item(CHAR_W'($urandom_range(0, 255)), $urandom_range(0, 7) == 0,
                          ROW_PRED, 8'h00, KIND_BYTE);
        send_char(CH_LBRACE);
        pairs = $urandom_range(1, 4);
        for (int p = 0; p < pairs; p++) begin
            r = $urandom_range(0, 99);
            gen_blank();
            gen_string(1'b0, 1'b0);
            gen_blank();
            if (r < 4) begin
                c = CHAR_W'($urandom_range(8'h21, 8'h7E));
                send_char((c == CH_COLON) ? 8'h78 : c);
            end
            send_char(CH_COLON);
            gen_blank();
            if (r >= 4 && r < 8)
                send_char(8'h31);
            gen_string(1'b1, r >= 8 && r < 13);
            gen_blank();
            send_char((p == pairs - 1) ? CH_RBRACE : CH_COMMA);
        end
        r = $urandom_range(0, 99);
        if (r < 50)
            send_item(CHAR_W'($urandom_range(0, 255)), 1'b1, ROW_PRED, 8'h00, KIND_BYTE);
        else if (r < 80)
            send_char(CH_NUL);
    endtask

    initial begin : stimulus
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        foreach (dir_rows[n])
            send_item(dir_rows[n].ch, dir_rows[n].eot, dir_rows[n].mode,
                      dir_rows[n].rb, dir_rows[n].rk);
        while (sent_cnt < DIR_N + RANDOM_ITEMS)
            gen_object();
        i_in_valid <= 1'b0;
        while (pending_values.size() != 0)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (err_cnt == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    // output side: random stalls plus one long hold-off that backs up the input
    initial begin : out_side
        int stall;
        bit rx_burst;
        bit held;
        stall = 0;
        rx_burst = 1'b0;
        held = 1'b0;
        forever begin
            @(posedge i_clk);
            if (!held && sent_cnt >= DIR_N + 250) begin
                held = 1'b1;
                stall = 400;
            end
            if (stall > 0) begin
                stall--;
                i_out_ready <= 1'b0;
            end else begin
                if ($urandom_range(0, 63) == 0)
                    rx_burst = !rx_burst;
                if (rx_burst || $urandom_range(0, 99) < 70) begin
                    i_out_ready <= 1'b1;
                end else begin
                    stall = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40) :
                                                          $urandom_range(0, 2);
                    i_out_ready <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        value_item_t want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_values.size() == 0) begin
                $display("%0t: unexpected item, expected none, actual byte %02h kind %0d",
                         $time, o_out_byte, o_out_kind);
                err_cnt++;
            end else begin
                want = pending_values.pop_front();
                if (o_out_kind !== want.k) begin
                    $display("%0t: out_kind mismatch, expected %0d, actual %0d",
                             $time, want.k, o_out_kind);
                    err_cnt++;
                end
                if (o_out_byte !== want.b) begin
                    $display("%0t: out_byte mismatch, expected %02h, actual %02h",
                             $time, want.b, o_out_byte);
                    err_cnt++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

endmodule
